FILE: sv/cal_pkg.sv
// Shared types and constants for the checked amount unit.
package cal_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;
	localparam logic [WordW-1:0] BpsDenominator = 64'd10000;

	typedef enum logic [2:0] {
		MODE_ADD   = 3'd0,
		MODE_SUB   = 3'd1,
		MODE_MUL   = 3'd2,
		MODE_BPS   = 3'd3,
		MODE_RATIO = 3'd4,
		MODE_MIN   = 3'd5,
		MODE_MAX   = 3'd6,
		MODE_SSUB  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_OVERFLOW     = 2'd1,
		ST_INSUFFICIENT = 2'd2,
		ST_ZERO_DEN     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [WordW-1:0] operand_a;
		logic [WordW-1:0] operand_b;
		logic [WordW-1:0] operand_c;
	} in_t;

	typedef struct packed {
		logic [WordW-1:0] result_value;
		logic [1:0]       status;
	} out_t;

	// One word as it travels down the divider stages.
	typedef struct packed {
		logic             valid;
		mode_t            mode;
		status_t          status;
		logic [WordW-1:0] value;
		logic [WordW-1:0] num;
		logic [WordW-1:0] den;
		logic [WordW-1:0] rem;
	} div_word_t;

endpackage

FILE: sv/cal_front.sv
// Front end: operand decode, partial products, product assembly and status.
module cal_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  cal_pkg::in_t        in_data,
	output cal_pkg::div_word_t  word_s2
);
	logic                            valid_s1;
	cal_pkg::mode_t                  mode_s1;
	cal_pkg::status_t                status_s1;
	logic [cal_pkg::WordW-1:0]       value_s1;
	logic [cal_pkg::WordW-1:0]       den_s1;
	logic [cal_pkg::WordW-1:0]       pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;

	cal_pkg::mode_t                  mode_in;
	logic [cal_pkg::WordW-1:0]       a, b, mb;
	logic [cal_pkg::WordW:0]         sum;
	cal_pkg::status_t                st_in;
	logic [cal_pkg::WordW-1:0]       val_in;

	always_comb begin
		mode_in = cal_pkg::mode_t'(in_data.mode);
		a = in_data.operand_a;
		b = in_data.operand_b;
		mb = (mode_in == cal_pkg::MODE_BPS) ? {{cal_pkg::HalfW{1'b0}}, b[cal_pkg::HalfW-1:0]} : b;
		sum = {1'b0, a} + {1'b0, b};
		st_in = cal_pkg::ST_OK;
		val_in = '0;
		unique case (mode_in)
			cal_pkg::MODE_ADD: begin
				if (sum[cal_pkg::WordW]) st_in = cal_pkg::ST_OVERFLOW;
				val_in = sum[cal_pkg::WordW-1:0];
			end
			cal_pkg::MODE_SUB: begin
				if (a < b) st_in = cal_pkg::ST_INSUFFICIENT;
				val_in = a - b;
			end
			cal_pkg::MODE_MIN:  val_in = (a < b) ? a : b;
			cal_pkg::MODE_MAX:  val_in = (a > b) ? a : b;
			cal_pkg::MODE_SSUB: val_in = (a > b) ? a - b : '0;
			cal_pkg::MODE_RATIO: begin
				if (in_data.operand_c == '0) st_in = cal_pkg::ST_ZERO_DEN;
			end
			default: val_in = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= mode_in;
			status_s1 <= st_in;
			value_s1  <= val_in;
			den_s1    <= (mode_in == cal_pkg::MODE_BPS) ? cal_pkg::BpsDenominator
			                                            : in_data.operand_c;
			pp_ll_s1  <= a[cal_pkg::HalfW-1:0] * mb[cal_pkg::HalfW-1:0];
			pp_lh_s1  <= a[cal_pkg::HalfW-1:0] * mb[cal_pkg::WordW-1:cal_pkg::HalfW];
			pp_hl_s1  <= a[cal_pkg::WordW-1:cal_pkg::HalfW] * mb[cal_pkg::HalfW-1:0];
			pp_hh_s1  <= a[cal_pkg::WordW-1:cal_pkg::HalfW] * mb[cal_pkg::WordW-1:cal_pkg::HalfW];
		end
	end

	// The middle sum carries the cross products plus the upper half of the low product.
	logic [cal_pkg::WordW+1:0]       mid;
	logic [cal_pkg::WordW-1:0]       prod;
	logic                            prod_ovf;
	cal_pkg::status_t                st_s1_next;
	logic                            is_mul;

	always_comb begin
		mid = {2'b00, pp_lh_s1} + {2'b00, pp_hl_s1}
		      + {{(cal_pkg::HalfW+2){1'b0}}, pp_ll_s1[cal_pkg::WordW-1:cal_pkg::HalfW]};
		prod = {mid[cal_pkg::HalfW-1:0], pp_ll_s1[cal_pkg::HalfW-1:0]};
		prod_ovf = (pp_hh_s1 != '0) || (mid[cal_pkg::WordW+1:cal_pkg::HalfW] != '0);
		is_mul = (mode_s1 == cal_pkg::MODE_MUL) || (mode_s1 == cal_pkg::MODE_BPS)
		         || (mode_s1 == cal_pkg::MODE_RATIO);
		st_s1_next = status_s1;
		if (is_mul && status_s1 == cal_pkg::ST_OK && prod_ovf) st_s1_next = cal_pkg::ST_OVERFLOW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s2 <= '0;
		end else if (en) begin
			word_s2.valid  <= valid_s1;
			word_s2.mode   <= mode_s1;
			word_s2.status <= st_s1_next;
			word_s2.value  <= (mode_s1 == cal_pkg::MODE_MUL) ? prod : value_s1;
			word_s2.num    <= prod;
			word_s2.den    <= den_s1;
			word_s2.rem    <= '0;
		end
	end

endmodule

FILE: sv/cal_div_stage.sv
// One restoring division step: brings down one dividend bit and sets one quotient bit.
module cal_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cal_pkg::div_word_t word_in,
	output cal_pkg::div_word_t word_out
);
	logic [cal_pkg::WordW:0] rem_n;
	logic [cal_pkg::WordW:0] rem_d;
	logic                    ge;

	always_comb begin
		rem_n = {word_in.rem, word_in.num[cal_pkg::WordW-1]};
		ge = rem_n >= {1'b0, word_in.den};
		rem_d = rem_n - {1'b0, word_in.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_out <= '0;
		end else if (en) begin
			word_out.valid  <= word_in.valid;
			word_out.mode   <= word_in.mode;
			word_out.status <= word_in.status;
			word_out.value  <= word_in.value;
			word_out.den    <= word_in.den;
			word_out.num    <= {word_in.num[cal_pkg::WordW-2:0], ge};
			word_out.rem    <= ge ? rem_d[cal_pkg::WordW-1:0] : rem_n[cal_pkg::WordW-1:0];
		end
	end

endmodule

FILE: sv/checked_amount_alu_unit.sv
// Top level of the checked 64-bit amount unit.
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_ready  | cal_pkg::in_t
//  out     | output    | out_valid / out_ready| cal_pkg::out_t
// One word may enter every cycle while the pipeline is not held; its result passes
// through two front stages, the first loaded at the edge that accepts it, 64 divider
// stages and one output register before it is offered.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and out_ready is low, and then in_ready is low.
// Reset clears every valid bit; no word is in flight afterwards.
module checked_amount_alu_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cal_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cal_pkg::out_t out_data
);
	logic               en;
	cal_pkg::div_word_t dw [0:cal_pkg::WordW];
	logic               out_valid_q;
	cal_pkg::out_t      out_data_q;
	logic               uses_quot;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	cal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.word_s2  (dw[0])
	);

	for (genvar i = 0; i < cal_pkg::WordW; i++) begin : g_div
		cal_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.word_in  (dw[i]),
			.word_out (dw[i+1])
		);
	end

	assign uses_quot = (dw[cal_pkg::WordW].mode == cal_pkg::MODE_BPS)
	                   || (dw[cal_pkg::WordW].mode == cal_pkg::MODE_RATIO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dw[cal_pkg::WordW].valid;
		end
	end

	// A failed check forces the value to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.status <= dw[cal_pkg::WordW].status;
			if (dw[cal_pkg::WordW].status != cal_pkg::ST_OK) begin
				out_data_q.result_value <= '0;
			end else if (uses_quot) begin
				out_data_q.result_value <= dw[cal_pkg::WordW].num;
			end else begin
				out_data_q.result_value <= dw[cal_pkg::WordW].value;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

FILE: sv/cal_checker.sv
// Port checker for the checked amount unit, bound to the top level.
module cal_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input cal_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input cal_pkg::out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word dropped or changed while stalled");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != cal_pkg::ST_OK |-> out_data.result_value == '0)
		else $error("non-zero value with failed status");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline is held");

endmodule

bind checked_amount_alu_unit cal_checker u_cal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: sim/checked_amount_alu_checker.sv
// Checker for the checked amount unit: predicts each result and compares it on arrival.
`timescale 1ns / 100ps
module checked_amount_alu_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  cal_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  cal_pkg::out_t out_data,
	output int            fail_count,
	output int            pending
);
	cal_pkg::out_t awaited_results[$];

	function automatic cal_pkg::out_t compute_amount(input cal_pkg::in_t w);
		logic [127:0] wide;
		logic [63:0]  a;
		logic [63:0]  b;
		logic [63:0]  c;
		cal_pkg::out_t r;
		a = w.operand_a;
		b = w.operand_b;
		c = w.operand_c;
		r.result_value = '0;
		r.status = cal_pkg::ST_OK;
		case (cal_pkg::mode_t'(w.mode))
			cal_pkg::MODE_ADD: begin
				wide = {64'd0, a} + {64'd0, b};
				if (wide[64]) r.status = cal_pkg::ST_OVERFLOW;
				else r.result_value = wide[63:0];
			end
			cal_pkg::MODE_SUB: begin
				if (a < b) r.status = cal_pkg::ST_INSUFFICIENT;
				else r.result_value = a - b;
			end
			cal_pkg::MODE_MUL: begin
				wide = {64'd0, a} * {64'd0, b};
				if (wide[127:64] != 0) r.status = cal_pkg::ST_OVERFLOW;
				else r.result_value = wide[63:0];
			end
			cal_pkg::MODE_BPS: begin
				wide = {64'd0, a} * {96'd0, b[31:0]};
				if (wide[127:64] != 0) r.status = cal_pkg::ST_OVERFLOW;
				else r.result_value = wide[63:0] / cal_pkg::BpsDenominator;
			end
			cal_pkg::MODE_RATIO: begin
				wide = {64'd0, a} * {64'd0, b};
				if (c == 0) r.status = cal_pkg::ST_ZERO_DEN;
				else if (wide[127:64] != 0) r.status = cal_pkg::ST_OVERFLOW;
				else r.result_value = wide[63:0] / c;
			end
			cal_pkg::MODE_MIN: r.result_value = (a < b) ? a : b;
			cal_pkg::MODE_MAX: r.result_value = (a > b) ? a : b;
			default: r.result_value = (a > b) ? a - b : 64'd0;
		endcase
		return r;
	endfunction

	assign pending = awaited_results.size();

	always @(posedge clk or negedge arst_n) begin
		cal_pkg::out_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(compute_amount(in_data));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result value=%h status=%0d", $time,
						out_data.result_value, out_data.status);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_results.pop_front();
					if (want.result_value !== out_data.result_value) begin
						$display("%0t: value expected %h actual %h", $time,
							want.result_value, out_data.result_value);
						fail_count <= fail_count + 1;
					end else if (want.status !== out_data.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, out_data.status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

FILE: sim/checked_amount_alu_unit_test.sv
// Testbench top: drives words into the checked amount unit and gives the verdict.
`timescale 1ns / 100ps
module checked_amount_alu_unit_test;
	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	cal_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	cal_pkg::out_t out_data;
	int            fail_count;
	int            pending;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            hold_off;

	checked_amount_alu_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	checked_amount_alu_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] pick_amount();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = v >> $urandom_range(0, 63);
			3: v = {32'd0, v[31:0]};
			4: v = {48'd0, v[15:0]};
			5: v = 64'd1 << $urandom_range(0, 63);
			default: ;
		endcase
		return v;
	endfunction

	// Offer one word and hold it until the unit takes it.
	task automatic send_word(input cal_pkg::mode_t m, input logic [63:0] a,
			input logic [63:0] b, input logic [63:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{mode: m, operand_a: a, operand_b: b, operand_c: c};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic random_phase(input int count);
		logic [63:0] a;
		logic [63:0] b;
		for (int i = 0; i < count; i++) begin
			a = pick_amount();
			b = pick_amount();
			// Often shrink the second operand so the product is more likely to fit, to reach the division.
			if ($urandom_range(0, 2) == 0) b = b >> (64 - $urandom_range(1, 63));
			send_word(cal_pkg::mode_t'($urandom_range(0, 7)), a, b, pick_amount());
		end
	endtask

	initial begin
		logic [63:0] mx;
		mx = '1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		hold_off = 0;
		send_idle_pct = 19;
		recv_idle_pct = 86;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(cal_pkg::MODE_ADD, mx, 64'd0, 64'd0);
		send_word(cal_pkg::MODE_ADD, mx, 64'd1, mx);
		send_word(cal_pkg::MODE_SUB, 64'd5, 64'd5, 64'd0);
		send_word(cal_pkg::MODE_SUB, 64'd4, 64'd5, 64'd0);
		send_word(cal_pkg::MODE_MUL, 64'd0, mx, 64'd0);
		send_word(cal_pkg::MODE_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 64'd0);
		send_word(cal_pkg::MODE_MUL, mx, 64'd1, 64'd0);
		send_word(cal_pkg::MODE_BPS, 64'd12345678, {32'hFFFF_FFFF, 32'd2500}, 64'd0);
		send_word(cal_pkg::MODE_BPS, mx, 64'd2, 64'd0);
		send_word(cal_pkg::MODE_BPS, 64'd9999, 64'd1, 64'd0);
		send_word(cal_pkg::MODE_BPS, mx, 64'hFFFF_FFFF_0000_0001, 64'd0);
		send_word(cal_pkg::MODE_RATIO, mx, mx, 64'd0);
		send_word(cal_pkg::MODE_RATIO, mx, 64'd2, 64'd3);
		send_word(cal_pkg::MODE_RATIO, 64'd1000, 64'd7, 64'd3);
		send_word(cal_pkg::MODE_RATIO, mx, 64'd1, mx);
		send_word(cal_pkg::MODE_MIN, mx, 64'd0, 64'd0);
		send_word(cal_pkg::MODE_MAX, 64'd0, mx, 64'd0);
		send_word(cal_pkg::MODE_SSUB, 64'd3, 64'd7, 64'd0);
		send_word(cal_pkg::MODE_SSUB, mx, 64'd0, mx);
		random_phase(600);
		send_idle_pct = 86;
		recv_idle_pct = 19;
		random_phase(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 300;
		random_phase(630);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end
endmodule
